>>> hw/rtl/parbp_pkg.sv
// Shared types and codes for the PWM audio ring buffer player.
package parbp_pkg;

  // Item operation codes
  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_PUSH   = 3'd1,
    MODE_PLAY   = 3'd2,
    MODE_PAUSE  = 3'd3,
    MODE_STOP   = 3'd4,
    MODE_STATUS = 3'd5
  } mode_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIDGE    = 2'd2;

  localparam int unsigned SAMPLE_W  = 8;
  localparam logic [SAMPLE_W-1:0] MID_LEVEL = 8'd127;

  // Per-item status carried from the control stage to the output stage
  typedef struct packed {
    logic left_load;     // left duty loads from read port A
    logic right_load;    // right duty loads this tick
    logic right_from_b;  // stereo: right comes from read port B, else copy of A
    logic playing;
    logic stopped;
    logic paused;
    logic seen;
    logic dropped;
  } item_flags_t;

endpackage

>>> hw/rtl/parbp_in_if.sv
// Input channel: operation beats with an optional sample byte.
interface parbp_in_if;
  import parbp_pkg::*;

  logic                valid;
  logic                ready;
  logic [2:0]          mode;
  logic [SAMPLE_W-1:0] sample_byte;

  modport source (output valid, output mode, output sample_byte, input ready);
  modport sink   (input valid, input mode, input sample_byte, output ready);
endinterface

>>> hw/rtl/parbp_out_if.sv
// Result channel: duty values and player status, one beat per item.
interface parbp_out_if #(
  parameter int unsigned FILL_W = 11
);
  import parbp_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] left_duty;
  logic [SAMPLE_W-1:0] right_duty;
  logic                left_updated;
  logic                right_updated;
  logic                is_playing;
  logic                is_stopped;
  logic                is_paused;
  logic                underrun_seen;
  logic [FILL_W-1:0]   fill_level;
  logic                push_dropped;

  modport source (
    output valid, output left_duty, output right_duty, output left_updated,
    output right_updated, output is_playing, output is_stopped, output is_paused,
    output underrun_seen, output fill_level, output push_dropped, input ready
  );
  modport sink (
    input valid, input left_duty, input right_duty, input left_updated,
    input right_updated, input is_playing, input is_stopped, input is_paused,
    input underrun_seen, input fill_level, input push_dropped, output ready
  );
endinterface

>>> hw/rtl/parbp_ram.sv
// Generic RAM: one write port, two registered read ports.
module parbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

>>> hw/rtl/parbp_ctrl.sv
// Control stage: ring indices, fill count, playback flags and RAM requests.
module parbp_ctrl #(
  parameter int unsigned BUFFER_BYTES = 1024,
  localparam int unsigned AW = $clog2(BUFFER_BYTES),
  localparam int unsigned CW = $clog2(BUFFER_BYTES + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  parbp_in_if.sink                          in_ch,
  input  logic                              cfg_we,
  input  logic [parbp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic                              cfg_data,
  input  logic                              s2_free,
  output logic                              s1_valid,
  output parbp_pkg::item_flags_t            s1_flags,
  output logic [CW-1:0]                     s1_fill,
  output logic                              ram_we,
  output logic [AW-1:0]                     ram_waddr,
  output logic [parbp_pkg::SAMPLE_W-1:0]    ram_wdata,
  output logic                              ram_re,
  output logic [AW-1:0]                     ram_raddr_a,
  output logic [AW-1:0]                     ram_raddr_b
);
  import parbp_pkg::*;

  localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_BYTES - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(BUFFER_BYTES);

  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [AW-1:0] wr_idx_r, wr_idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          playing_r, playing_nxt;
  logic          stopped_r, stopped_nxt;
  logic          underrun_r, underrun_nxt;
  logic          phase_r, phase_nxt;
  logic          half_rate_r, stereo_r, bridge_r;
  logic          s1_valid_r, s1_valid_nxt;
  item_flags_t   flags_r, flags_nxt;
  logic [CW-1:0] fill_r;

  logic          accept;
  logic          load;
  logic          seen;
  logic [AW-1:0] rd_idx_p1, rd_idx_p2, wr_idx_p1;

  // next ring positions, wrapping at any depth
  assign rd_idx_p1 = (rd_idx_r  == LAST_IDX) ? '0 : rd_idx_r  + AW'(1);
  assign rd_idx_p2 = (rd_idx_p1 == LAST_IDX) ? '0 : rd_idx_p1 + AW'(1);
  assign wr_idx_p1 = (wr_idx_r  == LAST_IDX) ? '0 : wr_idx_r  + AW'(1);

  assign in_ch.ready = !s1_valid_r || s2_free;
  assign accept      = in_ch.valid && in_ch.ready;

  // item decode and state update
  always_comb begin
    rd_idx_nxt   = rd_idx_r;
    wr_idx_nxt   = wr_idx_r;
    count_nxt    = count_r;
    playing_nxt  = playing_r;
    stopped_nxt  = stopped_r;
    underrun_nxt = underrun_r;
    phase_nxt    = phase_r;
    load         = 1'b0;
    flags_nxt    = '0;
    ram_we       = 1'b0;

    case (in_ch.mode)
      MODE_TICK: begin
        if (playing_r) begin
          if (half_rate_r) begin
            phase_nxt = !phase_r;
          end
          if (!half_rate_r || !phase_r) begin
            if (count_r > CW'(1)) begin
              load                = 1'b1;
              flags_nxt.left_load = 1'b1;
              if (stereo_r) begin
                count_nxt              = count_r - CW'(2);
                rd_idx_nxt             = rd_idx_p2;
                flags_nxt.right_load   = 1'b1;
                flags_nxt.right_from_b = 1'b1;
              end else begin
                count_nxt            = count_r - CW'(1);
                rd_idx_nxt           = rd_idx_p1;
                flags_nxt.right_load = bridge_r;
              end
            end else begin
              underrun_nxt = 1'b1;
            end
          end
        end
      end
      MODE_PUSH: begin
        if (count_r >= FULL_CNT) begin
          flags_nxt.dropped = 1'b1;
        end else begin
          ram_we     = accept;
          wr_idx_nxt = wr_idx_p1;
          count_nxt  = count_r + CW'(1);
        end
      end
      MODE_PLAY: begin
        // replay while playing restarts from an empty buffer
        if (playing_r) begin
          rd_idx_nxt = '0;
          wr_idx_nxt = '0;
          count_nxt  = '0;
        end
        playing_nxt = 1'b1;
        stopped_nxt = 1'b0;
      end
      MODE_PAUSE: begin
        if (!stopped_r) begin
          playing_nxt = !playing_r;
        end
      end
      MODE_STOP: begin
        rd_idx_nxt  = '0;
        wr_idx_nxt  = '0;
        count_nxt   = '0;
        playing_nxt = 1'b0;
        stopped_nxt = 1'b1;
      end
      default: begin
      end
    endcase

    seen = underrun_nxt;
    if (in_ch.mode == MODE_STATUS) begin
      underrun_nxt = 1'b0;
    end

    flags_nxt.playing = playing_nxt;
    flags_nxt.stopped = stopped_nxt;
    flags_nxt.paused  = !playing_nxt && !stopped_nxt;
    flags_nxt.seen    = seen;
  end

  // stage 1 occupancy
  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_free) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      count_r     <= '0;
      playing_r   <= 1'b0;
      stopped_r   <= 1'b1;
      underrun_r  <= 1'b0;
      phase_r     <= 1'b0;
      half_rate_r <= 1'b0;
      stereo_r    <= 1'b0;
      bridge_r    <= 1'b0;
      s1_valid_r  <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (accept) begin
        rd_idx_r   <= rd_idx_nxt;
        wr_idx_r   <= wr_idx_nxt;
        count_r    <= count_nxt;
        playing_r  <= playing_nxt;
        stopped_r  <= stopped_nxt;
        underrun_r <= underrun_nxt;
        phase_r    <= phase_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_HALF_RATE: half_rate_r <= cfg_data;
          CFG_STEREO:    stereo_r    <= cfg_data;
          CFG_BRIDGE:    bridge_r    <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      flags_r <= flags_nxt;
      fill_r  <= count_nxt;
    end
  end

  assign s1_valid    = s1_valid_r;
  assign s1_flags    = flags_r;
  assign s1_fill     = fill_r;
  assign ram_waddr   = wr_idx_r;
  assign ram_wdata   = in_ch.sample_byte;
  assign ram_re      = accept && load;
  assign ram_raddr_a = rd_idx_r;
  assign ram_raddr_b = rd_idx_p1;

endmodule

>>> hw/rtl/parbp_out.sv
// Output stage: duty registers loaded from RAM data, and the result register.
module parbp_out #(
  parameter int unsigned FILL_W = 11
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            s1_valid,
  input  parbp_pkg::item_flags_t          s1_flags,
  input  logic [FILL_W-1:0]               s1_fill,
  input  logic [parbp_pkg::SAMPLE_W-1:0]  rdata_a,
  input  logic [parbp_pkg::SAMPLE_W-1:0]  rdata_b,
  output logic                            s2_free,
  parbp_out_if.source                     out_ch
);
  import parbp_pkg::*;

  logic [SAMPLE_W-1:0] left_r, left_nxt;
  logic [SAMPLE_W-1:0] right_r, right_nxt;
  logic                out_valid_r;
  logic                advance;

  logic [SAMPLE_W-1:0] left_duty_r, right_duty_r;
  logic [FILL_W-1:0]   fill_level_r;
  item_flags_t         flags_out_r;

  assign s2_free = !out_valid_r || out_ch.ready;
  assign advance = s1_valid && s2_free;

  // duty update from the read data of this item
  always_comb begin
    left_nxt  = s1_flags.left_load ? rdata_a : left_r;
    right_nxt = right_r;
    if (s1_flags.right_load) begin
      right_nxt = s1_flags.right_from_b ? rdata_b : rdata_a;
    end
  end

  // duty state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= MID_LEVEL;
      right_r     <= MID_LEVEL;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        left_r      <= left_nxt;
        right_r     <= right_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (advance) begin
      left_duty_r  <= left_nxt;
      right_duty_r <= right_nxt;
      fill_level_r <= s1_fill;
      flags_out_r  <= s1_flags;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.left_duty     = left_duty_r;
  assign out_ch.right_duty    = right_duty_r;
  assign out_ch.left_updated  = flags_out_r.left_load;
  assign out_ch.right_updated = flags_out_r.right_load;
  assign out_ch.is_playing    = flags_out_r.playing;
  assign out_ch.is_stopped    = flags_out_r.stopped;
  assign out_ch.is_paused     = flags_out_r.paused;
  assign out_ch.underrun_seen = flags_out_r.seen;
  assign out_ch.fill_level    = fill_level_r;
  assign out_ch.push_dropped  = flags_out_r.dropped;

endmodule

>>> hw/rtl/pwm_audio_ring_buffer_player_unit.sv
// Top level of the PWM audio ring buffer player.
//
// Usage: each beat on in_ch is one operation (tick, push, play, pause, stop
// or status read); every accepted beat gives exactly one result beat on
// out_ch carrying both duty values, the update strobes, playback flags, the
// sticky underrun flag as seen by that beat, the fill level and the drop flag.
// Configuration (half rate, stereo, bridge) is written through cfg_we,
// cfg_index and cfg_data while the block is idle; bit 0 of the data is used.
// The result beat is registered in the output stage; the samples sit in
// one dual-read RAM with a registered read, issued at the accepting edge
// and consumed by the output stage when it takes the item.
// Throughput is one beat per cycle while out_ch does not stall; a stereo
// tick reads both bytes in the same cycle on the RAM's two read ports.
// Reset clears the indices, fill count and flags, leaves the player stopped
// with both duties at mid level; the sample RAM is not cleared, and needs no
// clearing pass, as reads never pass the pushed bytes.
// When out_ch stalls, one result waits in the output register and one more
// item is held in the control stage before in_ch.ready drops.
module pwm_audio_ring_buffer_player_unit #(
  parameter int unsigned BUFFER_BYTES = 1024,
  localparam int unsigned AW = $clog2(BUFFER_BYTES),
  localparam int unsigned CW = $clog2(BUFFER_BYTES + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  parbp_in_if.sink                        in_ch,
  parbp_out_if.source                     out_ch,
  input  logic                            cfg_we,
  input  logic [parbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                            cfg_data
);
  import parbp_pkg::*;

  logic                s2_free;
  logic                s1_valid;
  item_flags_t         s1_flags;
  logic [CW-1:0]       s1_fill;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr_a;
  logic [AW-1:0]       ram_raddr_b;
  logic [SAMPLE_W-1:0] ram_rdata_a;
  logic [SAMPLE_W-1:0] ram_rdata_b;

  // ring control
  parbp_ctrl #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s2_free     (s2_free),
    .s1_valid    (s1_valid),
    .s1_flags    (s1_flags),
    .s1_fill     (s1_fill),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr_a (ram_raddr_a),
    .ram_raddr_b (ram_raddr_b)
  );

  // sample store
  parbp_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (BUFFER_BYTES)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  // duties and result register
  parbp_out #(
    .FILL_W (CW)
  ) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_flags (s1_flags),
    .s1_fill  (s1_fill),
    .rdata_a  (ram_rdata_a),
    .rdata_b  (ram_rdata_b),
    .s2_free  (s2_free),
    .out_ch   (out_ch)
  );

endmodule

>>> bench/tb_pwm_audio_ring_buffer_player_unit.sv
// Self-checking testbench for the PWM audio ring buffer player: directed and random beats.
module tb_pwm_audio_ring_buffer_player_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import parbp_pkg::*;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned FILL_W = 11;
  localparam int unsigned RANDOM_PER_PHASE = 135;
  localparam int unsigned LONG_HOLD_CYCLES = 90;
  localparam int unsigned IDLE_PCT = 24;

  // modes the block ignores, and the register index it has no register for
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] left_duty;
    logic [SAMPLE_W-1:0] right_duty;
    logic                left_updated;
    logic                right_updated;
    logic                is_playing;
    logic                is_stopped;
    logic                is_paused;
    logic                underrun_seen;
    logic [FILL_W-1:0]   fill_level;
    logic                push_dropped;
  } duty_status_t;

  // Player model plus the queue of duty/status beats it predicts
  class player_scoreboard;
    logic [SAMPLE_W-1:0] samples [DEPTH];
    logic [9:0]          rd_ptr;
    logic [9:0]          wr_ptr;
    logic [FILL_W-1:0]   held;
    logic                playing;
    logic                stopped;
    logic                underrun;
    logic                phase;
    logic [SAMPLE_W-1:0] left_val;
    logic [SAMPLE_W-1:0] right_val;
    logic                half_rate;
    logic                stereo;
    logic                bridge;
    duty_status_t        due [$];
    int unsigned         failures;

    function new();
      rd_ptr = '0;
      wr_ptr = '0;
      held = '0;
      playing = 1'b0;
      stopped = 1'b1;
      underrun = 1'b0;
      phase = 1'b0;
      left_val = MID_LEVEL;
      right_val = MID_LEVEL;
      half_rate = 1'b0;
      stereo = 1'b0;
      bridge = 1'b0;
      failures = 0;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic val);
      case (idx)
        CFG_HALF_RATE: half_rate = val;
        CFG_STEREO:    stereo = val;
        CFG_BRIDGE:    bridge = val;
        default: ;
      endcase
    endfunction

    function void empty_buffer();
      playing = 1'b0;
      stopped = 1'b1;
      held = '0;
      rd_ptr = '0;
      wr_ptr = '0;
    endfunction

    // One accepted input beat: advance the model, queue the beat it yields
    function void note_input(logic [2:0] m, logic [SAMPLE_W-1:0] b);
      duty_status_t r;
      logic load;
      r = '0;
      case (m)
        MODE_TICK: begin
          if (playing) begin
            load = 1'b1;
            if (half_rate) begin
              phase = !phase;
              load = phase;
            end
            if (load) begin
              if (held > 1) begin
                left_val = samples[rd_ptr];
                rd_ptr++;
                r.left_updated = 1'b1;
                if (stereo) begin
                  right_val = samples[rd_ptr];
                  rd_ptr++;
                  held -= 2;
                  r.right_updated = 1'b1;
                end else begin
                  held -= 1;
                  if (bridge) begin
                    right_val = left_val;
                    r.right_updated = 1'b1;
                  end
                end
              end else begin
                underrun = 1'b1;
              end
            end
          end
        end
        MODE_PUSH: begin
          if (held >= DEPTH) begin
            r.push_dropped = 1'b1;
          end else begin
            samples[wr_ptr] = b;
            wr_ptr++;
            held++;
          end
        end
        MODE_PLAY: begin
          if (playing) empty_buffer();
          playing = 1'b1;
          stopped = 1'b0;
        end
        MODE_PAUSE: begin
          if (!stopped) playing = !playing;
        end
        MODE_STOP: empty_buffer();
        default: ;
      endcase
      r.underrun_seen = underrun;
      if (m == MODE_STATUS) underrun = 1'b0;
      r.left_duty = left_val;
      r.right_duty = right_val;
      r.is_playing = playing;
      r.is_stopped = stopped;
      r.is_paused = !playing && !stopped;
      r.fill_level = held;
      due.push_back(r);
    endfunction

    // One result beat against the oldest prediction
    function void check_result(duty_status_t got);
      duty_status_t exp;
      if (due.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result beat: %p", got);
        return;
      end
      exp = due.pop_front();
      if (got !== exp) begin
        failures++;
        if (failures <= 10) begin
          $display("result mismatch at %0t", $realtime);
          $display("  expected %p", exp);
          $display("  actual   %p", got);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic cfg_data;

  parbp_in_if in_if ();
  parbp_out_if #(.FILL_W(FILL_W)) out_if ();

  pwm_audio_ring_buffer_player_unit #(.BUFFER_BYTES(DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  player_scoreboard sb = new();
  bit steady;      // no idling on either side while set
  bit long_hold;   // asks the result side for one long hold-off

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Safety net against a hung handshake
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off on request
  initial begin : result_sink
    bit held_once;
    int unsigned n;
    held_once = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold && !held_once) begin
        held_once = 1'b1;
        out_if.ready <= 1'b0;
        for (n = 0; n < LONG_HOLD_CYCLES; n++) @(posedge clk);
      end
      out_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Result monitor
  always @(posedge clk) begin : result_monitor
    duty_status_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.left_duty = out_if.left_duty;
      got.right_duty = out_if.right_duty;
      got.left_updated = out_if.left_updated;
      got.right_updated = out_if.right_updated;
      got.is_playing = out_if.is_playing;
      got.is_stopped = out_if.is_stopped;
      got.is_paused = out_if.is_paused;
      got.underrun_seen = out_if.underrun_seen;
      got.fill_level = out_if.fill_level;
      got.push_dropped = out_if.push_dropped;
      sb.check_result(got);
    end
  end

  // Offer one beat, with random gaps first, and wait for it to be taken
  task automatic send_beat(input logic [2:0] m, input logic [SAMPLE_W-1:0] b);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode <= m;
    in_if.sample_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_input(m, b);
  endtask

  // Stop offering and wait until every predicted beat has come out
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (3) @(posedge clk);
  endtask

  // Write all three registers back to back; optionally poke the unused index
  task automatic apply_setting(input logic hr, input logic st, input logic br,
                               input bit poke_unused);
    cfg_we <= 1'b1;
    cfg_index <= CFG_HALF_RATE;
    cfg_data <= hr;
    @(posedge clk);
    sb.set_reg(CFG_HALF_RATE, hr);
    cfg_index <= CFG_STEREO;
    cfg_data <= st;
    @(posedge clk);
    sb.set_reg(CFG_STEREO, st);
    cfg_index <= CFG_BRIDGE;
    cfg_data <= br;
    @(posedge clk);
    sb.set_reg(CFG_BRIDGE, br);
    if (poke_unused) begin
      cfg_index <= CFG_NONE;
      cfg_data <= 1'b1;
      @(posedge clk);
      sb.set_reg(CFG_NONE, 1'b1);
    end
    cfg_we <= 1'b0;
  endtask

  // Weighted random beat: mostly pushes and ticks, some control, a little noise
  task automatic random_beat();
    int unsigned p;
    logic [2:0] m;
    p = $urandom_range(99);
    if (p < 42) m = MODE_PUSH;
    else if (p < 78) m = MODE_TICK;
    else if (p < 83) m = MODE_STATUS;
    else if (p < 88) m = MODE_PLAY;
    else if (p < 93) m = MODE_PAUSE;
    else if (p < 96) m = MODE_STOP;
    else if (p < 98) m = MODE_SPARE_LO;
    else m = MODE_SPARE_HI;
    send_beat(m, SAMPLE_W'($urandom_range(255)));
  endtask

  initial begin : stimulus
    logic [2:0] settings [6];
    int unsigned ph;
    int unsigned k;
    settings[0] = 3'b000;
    settings[1] = 3'b111;
    settings[2] = 3'b101;
    settings[3] = 3'b010;
    settings[4] = 3'b001;
    settings[5] = 3'b110;
    steady = 1'b0;
    long_hold = 1'b0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_HALF_RATE;
    cfg_data <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.mode <= MODE_TICK;
    in_if.sample_byte <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset state, mono playback to underrun, control corners
    send_beat(MODE_STATUS, 8'h00);
    send_beat(MODE_TICK, 8'h00);      // stopped: nothing moves
    send_beat(MODE_PUSH, 8'h00);
    send_beat(MODE_PUSH, 8'hFF);
    send_beat(MODE_PUSH, 8'h80);
    send_beat(MODE_PUSH, 8'h7F);
    send_beat(MODE_PLAY, 8'h00);
    send_beat(MODE_TICK, 8'h00);
    send_beat(MODE_TICK, 8'h00);
    send_beat(MODE_TICK, 8'h00);
    send_beat(MODE_TICK, 8'h00);      // one byte left: underrun
    send_beat(MODE_STATUS, 8'h00);    // sees it and clears
    send_beat(MODE_STATUS, 8'h00);
    send_beat(MODE_PAUSE, 8'h00);
    send_beat(MODE_TICK, 8'h00);      // paused: no phase, no load
    send_beat(MODE_PAUSE, 8'h00);     // resume
    send_beat(MODE_SPARE_LO, 8'hA5);
    send_beat(MODE_SPARE_HI, 8'h5A);
    send_beat(MODE_STOP, 8'h00);
    send_beat(MODE_PAUSE, 8'h00);     // ignored while stopped
    send_beat(MODE_PLAY, 8'h00);
    send_beat(MODE_PUSH, 8'h55);
    send_beat(MODE_PLAY, 8'h00);      // play while playing empties
    send_beat(MODE_PUSH, 8'hAA);
    send_beat(MODE_TICK, 8'h00);
    settle();

    // Random phases, one register setting each
    for (ph = 0; ph < 6; ph++) begin
      apply_setting(settings[ph][2], settings[ph][1], settings[ph][0], ph == 0);
      if (ph == 0) begin
        // fill to the brim with no idling, overflow, then drain and wrap
        steady = 1'b1;
        send_beat(MODE_STOP, 8'h00);
        for (k = 0; k < DEPTH + 6; k++) send_beat(MODE_PUSH, SAMPLE_W'($urandom_range(255)));
        send_beat(MODE_PLAY, 8'h00);
        for (k = 0; k < 80; k++) begin
          send_beat(k[0] ? MODE_PUSH : MODE_TICK, SAMPLE_W'($urandom_range(255)));
        end
        steady = 1'b0;
      end
      if (ph == 1) long_hold = 1'b1;
      for (k = 0; k < RANDOM_PER_PHASE; k++) random_beat();
      settle();
    end

    // Catch stray beats after the last expected one
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
